### hdl/sha1_pkg.sv
// Shared types and constants for the SHA-1 message hasher.
// Used by sha1_ctrl, sha1_datapath and the top level; depends on nothing.
package sha1_pkg;

    localparam int WORDS = 5;

    localparam logic [31:0] IV_WORD [WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] K_ROUND [4] = '{
        32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] FILL_FULL = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd55;  // last slot before the length field
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_ZERO,
        ST_LEN,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } t_state;

    // where to go once a compression finishes
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_ZERO,
        RET_OUT
    } t_ret;

    typedef enum logic [1:0] {
        SEL_MSG,
        SEL_80,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    // round function group, one per 20 rounds; also indexes K_ROUND
    typedef enum logic [1:0] {
        FN_CHOOSE,
        FN_PARITY1,
        FN_MAJORITY,
        FN_PARITY2
    } t_round_fn;

    typedef struct packed {
        logic      push;
        t_byte_sel sel;
        logic      count_en;
        logic      load;
        logic      round_en;
        t_round_fn stage;
        logic      add;
        logic      init;
        logic [2:0] word_idx;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_status;

endpackage

### hdl/sha1_message_hasher.sv
// SHA-1 message hasher, top level: joins sha1_ctrl and sha1_datapath.
// Depends on sha1_pkg, sha1_ctrl, sha1_datapath.
//
// Usage:
//   Slave channel: one request per message byte. tdata = data byte, tuser = byte
//   present, tlast = end of message. A request with tlast and no byte closes the
//   message as it stands (empty message if nothing came before).
//   Master channel: five requests per message, digest words 0..4, tuser = index,
//   tlast on word 4.
// Sequence:
//   The byte that completes a 64-byte block holds tready low through the
//   80 rounds of the single round unit and then the chaining add.
//   After the end request the padding goes in one byte per cycle: (64 - fill)
//   bytes, plus 64 more and a second compression when fill >= 56, then the
//   last compression, then the digest words, one per cycle while m_axis_tready
//   is high.
// Reset and stalls:
//   Reset loads the initial chaining words and clears the bit count. While the
//   receiver holds tready low the current word stays on the bus and no new
//   bytes are taken; after word 4 the block starts a fresh message.
module sha1_message_hasher
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    t_cmd    cmd;
    t_status status;

    sha1_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_has_byte  (s_axis_tuser),
        .i_end       (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_last  (m_axis_tlast),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sha1_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_byte        (s_axis_tdata),
        .o_status      (status),
        .o_digest_word (m_axis_tdata)
    );

    assign m_axis_tuser = cmd.word_idx;

endmodule

### hdl/sha1_ctrl.sv
// Sequencer for the SHA-1 hasher: byte intake, padding, rounds, digest output.
// Depends on sha1_pkg; drives sha1_datapath through t_cmd.
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_has_byte,
    input  logic    i_end,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output logic    o_out_last,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    t_ret       r_ret, n_ret;
    logic [6:0] r_round, n_round;
    logic [2:0] r_word, n_word;

    logic fill_full, fill_len;
    assign fill_full = (i_status.fill == FILL_FULL);
    assign fill_len  = (i_status.fill == FILL_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= RET_IDLE;
            r_round <= '0;
            r_word  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
            r_word  <= n_word;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_round = '0;
        n_word  = r_word;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_has_byte && fill_full) begin
                        n_state = ST_COMP;
                        n_ret   = i_end ? RET_PAD : RET_IDLE;
                    end else if (i_end) begin
                        n_state = ST_PAD80;
                    end
                end
            end
            ST_PAD80, ST_ZERO: begin
                if (fill_full) begin
                    n_state = ST_COMP;
                    n_ret   = RET_ZERO;
                end else if (fill_len) begin
                    n_state = ST_LEN;
                end else begin
                    n_state = ST_ZERO;
                end
            end
            ST_LEN: begin
                if (fill_full) begin
                    n_state = ST_COMP;
                    n_ret   = RET_OUT;
                end
            end
            ST_COMP: begin
                if (r_round == LAST_ROUND) begin
                    n_state = ST_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            ST_ADD: begin
                unique case (r_ret)
                    RET_IDLE: n_state = ST_IDLE;
                    RET_PAD:  n_state = ST_PAD80;
                    RET_ZERO: n_state = ST_ZERO;
                    RET_OUT:  n_state = ST_OUT;
                endcase
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    if (r_word == LAST_WORD) begin
                        n_state = ST_IDLE;
                        n_word  = '0;
                    end else begin
                        n_word = r_word + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.sel      = SEL_MSG;
        o_cmd.word_idx = r_word;
        o_in_ready     = (r_state == ST_IDLE);
        o_out_valid    = (r_state == ST_OUT);
        o_out_last     = (r_state == ST_OUT) && (r_word == LAST_WORD);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.push     = i_in_valid && i_has_byte;
                o_cmd.count_en = i_in_valid && i_has_byte;
            end
            ST_PAD80: begin
                o_cmd.push = 1'b1;
                o_cmd.sel  = SEL_80;
            end
            ST_ZERO: begin
                o_cmd.push = 1'b1;
                o_cmd.sel  = SEL_ZERO;
            end
            ST_LEN: begin
                o_cmd.push = 1'b1;
                o_cmd.sel  = SEL_LEN;
            end
            ST_COMP: begin
                o_cmd.round_en = 1'b1;
                if (r_round < 7'd20)      o_cmd.stage = FN_CHOOSE;
                else if (r_round < 7'd40) o_cmd.stage = FN_PARITY1;
                else if (r_round < 7'd60) o_cmd.stage = FN_MAJORITY;
                else                      o_cmd.stage = FN_PARITY2;
            end
            ST_ADD: o_cmd.add = 1'b1;
            ST_OUT: o_cmd.init = i_out_ready && (r_word == LAST_WORD);
            default: o_cmd.push = 1'b0;
        endcase
        // the byte that fills a block also seeds the round variables
        o_cmd.load = o_cmd.push && fill_full;
    end

endmodule

### hdl/sha1_datapath.sv
// SHA-1 datapath: 512-bit schedule window, round unit, chaining words, bit count.
// Depends on sha1_pkg; commanded by sha1_ctrl.
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_byte,
    output t_status     o_status,
    output logic [31:0] o_digest_word
);

    logic [511:0] r_win;
    logic [31:0]  r_v [WORDS];
    logic [31:0]  r_h [WORDS];
    logic [63:0]  r_count;
    logic [5:0]   r_fill;

    logic [7:0]  push_byte;
    logic [31:0] w0, w2, w8, w13, w_x, w_new;
    logic [31:0] a, b, c, d, e, f, t;

    // window word i sits at bits [511-32*i -: 32]
    assign w0  = r_win[511:480];
    assign w2  = r_win[447:416];
    assign w8  = r_win[255:224];
    assign w13 = r_win[95:64];
    assign w_x   = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_x[30:0], w_x[31]};

    assign a = r_v[0];
    assign b = r_v[1];
    assign c = r_v[2];
    assign d = r_v[3];
    assign e = r_v[4];

    always_comb begin
        unique case (i_cmd.stage)
            FN_CHOOSE:   f = (b & c) | (~b & d);
            FN_MAJORITY: f = (b & c) | (b & d) | (c & d);
            default:     f = b ^ c ^ d;
        endcase
    end

    assign t = {a[26:0], a[31:27]} + f + e + w0 + K_ROUND[i_cmd.stage];

    always_comb begin
        unique case (i_cmd.sel)
            SEL_MSG:  push_byte = i_byte;
            SEL_80:   push_byte = PAD_BYTE;
            SEL_ZERO: push_byte = 8'h00;
            SEL_LEN:  push_byte = r_count[{~r_fill[2:0], 3'b000} +: 8];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_win <= {r_win[503:0], push_byte};
        end else if (i_cmd.round_en) begin
            r_win <= {r_win[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < WORDS; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round_en) begin
            r_v[0] <= t;
            r_v[1] <= a;
            r_v[2] <= {b[1:0], b[31:2]};
            r_v[3] <= c;
            r_v[4] <= d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            for (int i = 0; i < WORDS; i++) r_h[i] <= IV_WORD[i];
            r_count <= '0;
            r_fill  <= '0;
        end else begin
            if (i_cmd.add) begin
                for (int i = 0; i < WORDS; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.count_en) r_count <= r_count + 64'd8;
            if (i_cmd.push)     r_fill  <= r_fill + 6'd1;
        end
    end

    assign o_status.fill = r_fill;

    always_comb begin
        unique case (i_cmd.word_idx)
            3'd0:    o_digest_word = r_h[0];
            3'd1:    o_digest_word = r_h[1];
            3'd2:    o_digest_word = r_h[2];
            3'd3:    o_digest_word = r_h[3];
            3'd4:    o_digest_word = r_h[4];
            default: o_digest_word = '0;
        endcase
    end

endmodule

### hdl/sha1_checker.sv
// Port-level checks for sha1_message_hasher, attached by the bind below.
// Depends on nothing but the top level's ports.
module sha1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // no byte is taken while the digest is being sent
    a_no_intake_during_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while digest pending");

    a_last_on_word4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd4)))
        else $error("tlast not aligned with word index 4");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("digest word index did not advance");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after final digest word");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled digest word changed");

endmodule

bind sha1_message_hasher sha1_checker u_sha1_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
